// File: hdl/t2ns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t2ns_pkg
// Shared types and constants for the tick to nanosecond converter: the word
// widths, the scale factor and the state carried between divider stages.
// ----------------------------------------------------------------------------
package t2ns_pkg;

  // Word widths.
  localparam int unsigned TICK_W  = 64;
  localparam int unsigned RATE_W  = 32;
  localparam int unsigned SCALE_W = 30;
  localparam int unsigned PROD_W  = TICK_W + SCALE_W;

  // Nanoseconds in one second; fits in 30 bits.
  localparam logic [SCALE_W-1:0] NS_PER_SEC = 30'd1000000000;

  // One quotient bit is produced per divider stage.
  localparam int unsigned DIV_STAGES = TICK_W;

  // Delay from the accepting edge to the edge that takes the result, through
  // the multiply, add, range check, divider stages and output register.
  localparam int unsigned LATENCY = DIV_STAGES + 4;

  // Register map.
  localparam logic [1:0] ADDR_TICK_RATE = 2'd0;

  // State handed from one divider stage to the next. The word holds the
  // dividend bits not yet consumed in its upper part and the quotient bits
  // produced so far in its lower part.
  typedef struct packed {
    logic              valid;
    logic              sat;
    logic [RATE_W-1:0] rem;
    logic [TICK_W-1:0] word;
  } div_state_t;

endpackage

// File: hdl/t2ns_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t2ns_div_step
// One registered stage of the restoring divider: brings in the next dividend
// bit, subtracts the rate where it fits and shifts in one quotient bit.
// ----------------------------------------------------------------------------
module t2ns_div_step
  import t2ns_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [RATE_W-1:0] rate,
  input  div_state_t        din,
  output div_state_t        dout
);

  logic [RATE_W:0]   trial;
  logic [RATE_W-1:0] diff;
  logic              fits;
  logic [RATE_W-1:0] rem_next;

  // Partial remainder with the next dividend bit appended, and the trial subtract.
  // The partial remainder stays below the rate, so the difference fits in
  // the rate's width whenever the subtract is taken.
  always_comb begin
    trial    = {din.rem, din.word[TICK_W-1]};
    diff     = trial[RATE_W-1:0] - rate;
    fits     = (trial >= {1'b0, rate});
    rem_next = fits ? diff : trial[RATE_W-1:0];
  end

  // Valid bit is cleared by reset; the payload follows it without reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.sat  <= din.sat;
    dout.rem  <= rem_next;
    dout.word <= {din.word[TICK_W-2:0], fits};
  end

endmodule

// File: hdl/ticks_to_nanoseconds.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ticks_to_nanoseconds
// Converts a 64-bit tick count into nanoseconds at a configured tick rate,
// saturating to all ones when the result does not fit in 64 bits.
// ----------------------------------------------------------------------------
// The block takes a new tick word in every cycle (busy never rises) and
// returns each result through registers for the 64 by 30 bit scale multiply
// and its sum, the range check, the bit-per-stage divider by the tick rate,
// and the output register. The result is shown on nanoseconds and saturated
// for one cycle, marked by done, and must be taken then. The tick rate is
// written over the APB port at byte address 0; the user must write it only
// while no word is in flight, which the block does not enforce. A rate of
// zero gives a result of zero.
module ticks_to_nanoseconds
  import t2ns_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Command channel.
  input  logic              start,
  output logic              busy,
  input  logic [TICK_W-1:0] ticks,
  output logic              done,
  output logic [TICK_W-1:0] nanoseconds,
  output logic              saturated,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [RATE_W-1:0] tick_rate_hz;
  logic              cfg_write;

  logic                    s1_valid;
  logic [TICK_W-3:0]       s1_lo;
  logic [TICK_W-3:0]       s1_hi;
  logic                    s2_valid;
  logic [PROD_W-1:0]       s2_prod;
  div_state_t              div_in;
  div_state_t              stage [0:DIV_STAGES];

  // The pipeline never stalls.
  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Configuration register write and read.
  assign cfg_write = psel && penable && pwrite && (paddr == ADDR_TICK_RATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate_hz <= '0;
    end else if (cfg_write) begin
      tick_rate_hz <= pwdata;
    end
  end

  assign prdata = (paddr == ADDR_TICK_RATE) ? tick_rate_hz : 32'd0;

  // Stage 1: scale both halves of the tick count by one billion.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_lo <= 62'(ticks[31:0]) * 62'(NS_PER_SEC);
    s1_hi <= 62'(ticks[63:32]) * 62'(NS_PER_SEC);
  end

  // Stage 2: combine the partial products into the full scaled count.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_prod <= {s1_hi, 32'd0} + PROD_W'(s1_lo);
  end

  // Stage 3: the quotient needs more than 64 bits exactly when the top
  // bits of the scaled count reach the rate; otherwise they seed the
  // partial remainder and the low 64 bits feed the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_in.valid <= 1'b0;
    end else begin
      div_in.valid <= s2_valid;
    end
    div_in.sat  <= ({2'b00, s2_prod[PROD_W-1:TICK_W]} >= tick_rate_hz);
    div_in.rem  <= {2'b00, s2_prod[PROD_W-1:TICK_W]};
    div_in.word <= s2_prod[TICK_W-1:0];
  end

  assign stage[0] = div_in;

  // Divider chain, one quotient bit per stage.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    t2ns_div_step u_step (
      .clk  (clk),
      .rst  (rst),
      .rate (tick_rate_hz),
      .din  (stage[g]),
      .dout (stage[g+1])
    );
  end

  // Output register: zero rate, saturation or the quotient.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage[DIV_STAGES].valid;
    end
    if (tick_rate_hz == '0) begin
      nanoseconds <= '0;
      saturated   <= 1'b0;
    end else if (stage[DIV_STAGES].sat) begin
      nanoseconds <= '1;
      saturated   <= 1'b1;
    end else begin
      nanoseconds <= stage[DIV_STAGES].word;
      saturated   <= 1'b0;
    end
  end

endmodule

// File: hdl/t2ns_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t2ns_checker
// Port-level checks for the tick to nanosecond converter: fixed latency from
// accepted word to result strobe, and the form of a saturated result.
// ----------------------------------------------------------------------------
module t2ns_checker
  import t2ns_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [TICK_W-1:0] nanoseconds,
  input logic              saturated,
  input logic              pready
);

  // Every accepted word produces a result strobe after the fixed latency.
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted word produced no result at the expected cycle");

  // No result strobe appears without a word accepted at the matching edge.
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching accepted word");

  // A saturated result is clamped to all ones.
  a_sat_all_ones: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (nanoseconds == {TICK_W{1'b1}}))
    else $error("saturated result is not all ones");

  // The configuration port never inserts wait states.
  a_no_wait: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("configuration port inserted a wait state");

endmodule

bind ticks_to_nanoseconds t2ns_checker u_t2ns_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .nanoseconds (nanoseconds),
  .saturated   (saturated),
  .pready      (pready)
);
